// File: design/indexed_list_queue_engine_defines.svh
// Assertion macros for the checker file of the list queue engine.
`ifndef INDEXED_LIST_QUEUE_ENGINE_DEFINES_SVH
`define INDEXED_LIST_QUEUE_ENGINE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ILQE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list queue engine check failed");

// Consequent checked in the cycle after the antecedent.
`define ILQE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list queue engine check failed");

`endif

// File: design/ilqe_pkg.sv
// Types and constants shared by the list queue engine modules.
`timescale 1ns / 1ps
package ilqe_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 32;
  localparam int FPOS_W = 5;
  localparam int CNT_W  = 5;
  localparam int ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_GET    = 3'd2,
    OP_FIND   = 3'd3,
    OP_PUSH   = 3'd4,
    OP_POP    = 3'd5,
    OP_FRONT  = 3'd6,
    OP_BACK   = 3'd7
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Per-cell controls decoded by the top level.
  typedef struct packed {
    logic load_in;     // take the incoming word
    logic load_left;   // take the word of the lower neighbor (shift up)
    logic load_right;  // take the word of the upper neighbor (shift down)
    logic pick;        // this cell is the addressed one for a read
    logic seek;        // this cell takes part in a search
  } cell_ctl_t;

endpackage

// File: design/ilqe_cell.sv
// One list cell: holds one word and one stage of the result lane.
`timescale 1ns / 1ps
module ilqe_cell import ilqe_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [WIDTH-1:0] key_i,
  input  logic [WIDTH-1:0] left_i,
  input  logic [WIDTH-1:0] right_i,
  input  logic             lane_hit_i,
  input  logic [IW-1:0]    lane_idx_i,
  input  logic [WIDTH-1:0] lane_data_i,
  output logic [WIDTH-1:0] data_o,
  output logic             lane_hit_o,
  output logic [IW-1:0]    lane_idx_o,
  output logic [WIDTH-1:0] lane_data_o
);

  logic [WIDTH-1:0] data_q;
  logic             hit_q;
  logic [IW-1:0]    idx_q;
  logic [WIDTH-1:0] ldata_q;
  logic             sel;

  // A selected cell overrides the lane word coming down from above, so the
  // lowest selected position reaches the head of the lane.
  assign sel = ctl_i.pick | (ctl_i.seek & (data_q == key_i));

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      data_q <= wdata_i;
    end else if (ctl_i.load_left) begin
      data_q <= left_i;
    end else if (ctl_i.load_right) begin
      data_q <= right_i;
    end
    if (sel) begin
      idx_q   <= IW'(INDEX);
      ldata_q <= data_q;
    end else begin
      idx_q   <= lane_idx_i;
      ldata_q <= lane_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= sel | lane_hit_i;
    end
  end

  assign data_o      = data_q;
  assign lane_hit_o  = hit_q;
  assign lane_idx_o  = idx_q;
  assign lane_data_o = ldata_q;

endmodule

// File: design/indexed_list_queue_engine.sv
// Top level of the list queue engine: command decode, count and the cell row.
//
//  channel  | handshake              | words
//  ---------+------------------------+-----------------------------------------
//  command  | start_i / busy_o       | op_i, position_i, item_value_i
//  result   | done_o (one-cycle)     | read_value_o, found_position_o,
//           |                        | entry_count_o, status_o
//
// Insert, erase and push need no scan; the result strobes in the next cycle.
// Get, find, pop, front and back hold busy_o while the result lane moves one
// cell a cycle from the tail cell to the head cell; the result then strobes.
// Reset empties the list; stored words are not cleared.
// Results cannot be stalled: each is shown for exactly one cycle.
`timescale 1ns / 1ps
module indexed_list_queue_engine import ilqe_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [VAL_W-1:0]  item_value_i,
  output logic                     done_o,
  output logic signed [VAL_W-1:0]  read_value_o,
  output logic signed [FPOS_W-1:0] found_position_o,
  output logic [CNT_W-1:0]         entry_count_o,
  output logic [ST_W-1:0]          status_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       scan_q;
  logic [CW-1:0]       count_q;
  op_e                 op_q;
  logic [POS_W-1:0]    pos_q;
  logic [WIDTH-1:0]    key_q;
  status_e             status_q;
  logic                done_q;
  logic [VAL_W-1:0]    read_q;
  logic [FPOS_W-1:0]   fpos_q;
  logic [CNT_W-1:0]    ecount_q;

  op_e                 op;
  logic                accept;
  logic                full;
  logic                empty;
  logic                pos_oob;
  logic [PW-1:0]       pos_ext;
  logic [PW-1:0]       cnt_ext;
  logic [PW-1:0]       wr_pos;
  logic [PW-1:0]       er_pos;
  logic [PW-1:0]       qpos_ext;
  logic [PW-1:0]       tail;
  logic                wr_go;
  logic                er_go;
  status_e             rd_status;
  logic [63:0]         val_ext;
  logic [WIDTH-1:0]    wdata;
  logic [63:0]         lane_ext;

  cell_ctl_t           ctl   [DEPTH];
  logic [WIDTH-1:0]    data  [DEPTH];
  logic                lhit  [DEPTH];
  logic [IW-1:0]       lidx  [DEPTH];
  logic [WIDTH-1:0]    ldata [DEPTH];

  assign op      = op_e'(op_i);
  assign busy_o  = (state_q == S_SCAN);
  assign accept  = start_i & ~busy_o;
  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);
  assign pos_ext = PW'(position_i);
  assign cnt_ext = PW'(count_q);
  assign pos_oob = (pos_ext >= cnt_ext);
  assign wr_pos  = ((op == OP_PUSH) || pos_oob) ? '0 : pos_ext;
  assign er_pos  = pos_oob ? '0 : pos_ext;
  assign wr_go   = accept & ((op == OP_INSERT) || (op == OP_PUSH)) & ~full;
  assign er_go   = accept & (op == OP_ERASE) & ~empty;
  assign qpos_ext = PW'(pos_q);
  assign tail    = cnt_ext - PW'(1);

  always_comb begin
    val_ext = 64'(unsigned'(item_value_i));
    wdata   = val_ext[WIDTH-1:0];
    lane_ext = '0;
    lane_ext[WIDTH-1:0] = ldata[0];
  end

  always_comb begin
    rd_status = ST_OK;
    case (op) inside
      OP_GET: begin
        if (empty) begin
          rd_status = ST_EMPTY;
        end else if (pos_oob) begin
          rd_status = ST_RANGE;
        end
      end
      OP_POP, OP_FRONT, OP_BACK: begin
        if (empty) begin
          rd_status = ST_EMPTY;
        end
      end
      default: rd_status = ST_OK;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      ctl[i].load_in    = wr_go & (PW'(i) == wr_pos);
      ctl[i].load_left  = wr_go & (PW'(i) > wr_pos);
      ctl[i].load_right = er_go & (PW'(i) >= er_pos);
      ctl[i].seek       = (op_q == OP_FIND) & (PW'(i) < cnt_ext);
      case (op_q) inside
        OP_GET:           ctl[i].pick = (PW'(i) == qpos_ext);
        OP_POP, OP_FRONT: ctl[i].pick = (PW'(i) == tail);
        OP_BACK:          ctl[i].pick = (i == 0);
        default:          ctl[i].pick = 1'b0;
      endcase
    end

    ilqe_cell #(
      .WIDTH (WIDTH),
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl[i]),
      .wdata_i     (wdata),
      .key_i       (key_q),
      .left_i      ((i == 0) ? '0 : data[(i == 0) ? 0 : i - 1]),
      .right_i     ((i == DEPTH - 1) ? '0 : data[(i == DEPTH - 1) ? i : i + 1]),
      .lane_hit_i  ((i == DEPTH - 1) ? 1'b0 : lhit[(i == DEPTH - 1) ? i : i + 1]),
      .lane_idx_i  ((i == DEPTH - 1) ? '0 : lidx[(i == DEPTH - 1) ? i : i + 1]),
      .lane_data_i ((i == DEPTH - 1) ? '0 : ldata[(i == DEPTH - 1) ? i : i + 1]),
      .data_o      (data[i]),
      .lane_hit_o  (lhit[i]),
      .lane_idx_o  (lidx[i]),
      .lane_data_o (ldata[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scan_q   <= '0;
      count_q  <= '0;
      op_q     <= OP_INSERT;
      pos_q    <= '0;
      key_q    <= '0;
      status_q <= ST_OK;
      done_q   <= 1'b0;
      read_q   <= '0;
      fpos_q   <= '0;
      ecount_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= op;
            pos_q    <= position_i;
            key_q    <= wdata;
            read_q   <= '0;
            fpos_q   <= '0;
            unique case (op) inside
              OP_INSERT, OP_PUSH: begin
                done_q <= 1'b1;
                if (full) begin
                  status_q <= ST_FULL;
                  ecount_q <= CNT_W'(count_q);
                end else begin
                  status_q <= ST_OK;
                  count_q  <= count_q + CW'(1);
                  ecount_q <= CNT_W'(count_q + CW'(1));
                end
              end
              OP_ERASE: begin
                done_q <= 1'b1;
                if (empty) begin
                  status_q <= ST_EMPTY;
                  ecount_q <= CNT_W'(count_q);
                end else begin
                  status_q <= ST_OK;
                  count_q  <= count_q - CW'(1);
                  ecount_q <= CNT_W'(count_q - CW'(1));
                end
              end
              default: begin
                done_q   <= 1'b0;
                status_q <= rd_status;
                state_q  <= S_SCAN;
                scan_q   <= CW'(DEPTH);
              end
            endcase
          end else begin
            done_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_q != '0) begin
            scan_q <= scan_q - CW'(1);
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            if ((op_q == OP_POP) && (status_q == ST_OK)) begin
              count_q  <= count_q - CW'(1);
              ecount_q <= CNT_W'(count_q - CW'(1));
            end else begin
              ecount_q <= CNT_W'(count_q);
            end
            if (op_q == OP_FIND) begin
              fpos_q <= lhit[0] ? FPOS_W'(lidx[0]) : '1;
            end else if (status_q == ST_OK) begin
              read_q <= lane_ext[VAL_W-1:0];
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o           = done_q;
  assign read_value_o     = signed'(read_q);
  assign found_position_o = signed'(fpos_q);
  assign entry_count_o    = ecount_q;
  assign status_o         = status_q;

endmodule

// File: design/ilqe_checker.sv
// Port-level checks for the list queue engine, bound to the top level.
`timescale 1ns / 1ps
`include "indexed_list_queue_engine_defines.svh"
module ilqe_checker import ilqe_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     done_o,
  input logic signed [VAL_W-1:0]  read_value_o,
  input logic [CNT_W-1:0]         entry_count_o,
  input logic [ST_W-1:0]          status_o
);

  // An accepted word either answers in the next cycle or starts a scan.
  `ILQE_ASSERT_NEXT(a_accept_moves, clk_i, rst_ni, start_i && !busy_o, done_o || busy_o)
  // The end of a scan always delivers its result word.
  `ILQE_ASSERT_NOW(a_scan_ends_done, clk_i, rst_ni, $fell(busy_o), done_o)
  `ILQE_ASSERT_NOW(a_full_count, clk_i, rst_ni, done_o && status_o == ST_FULL,
    entry_count_o == CNT_W'(DEPTH))
  `ILQE_ASSERT_NOW(a_empty_count, clk_i, rst_ni, done_o && status_o == ST_EMPTY,
    entry_count_o == '0)
  // Failed reads return zero.
  `ILQE_ASSERT_NOW(a_error_zero, clk_i, rst_ni, done_o && status_o != ST_OK,
    read_value_o == '0)

endmodule

bind indexed_list_queue_engine ilqe_checker #(.DEPTH(DEPTH)) u_ilqe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .read_value_o  (read_value_o),
  .entry_count_o (entry_count_o),
  .status_o      (status_o)
);

// File: tb/indexed_list_queue_engine_test.sv
// Testbench for the list queue engine: random and directed commands checked against a predictor.
`timescale 1ns / 1ps
module indexed_list_queue_engine_test;
  import ilqe_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1250;
  localparam logic [FPOS_W-1:0] NOT_FOUND = '1;

  typedef struct {
    logic [VAL_W-1:0]  read_value;
    logic [FPOS_W-1:0] found_position;
    logic [CNT_W-1:0]  entry_count;
    status_e           status;
  } list_reply_t;

  typedef enum int {FILLING, DRAINING, MIXING} stim_mode_e;

  class list_scoreboard;
    logic [VAL_W-1:0] words[LIST_DEPTH];
    int               fill;
    list_reply_t      expected_replies[$];
    int               errors;

    function new();
      foreach (words[i]) words[i] = '0;
      fill = 0;
      errors = 0;
    endfunction

    // Applies one accepted command to the list copy and queues the reply it must give.
    function void note_command(op_e op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
      list_reply_t r;
      int          at;
      r.read_value = '0;
      r.found_position = '0;
      r.status = ST_OK;
      case (op)
        OP_INSERT, OP_PUSH: begin
          if (fill >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            at = (op == OP_PUSH || pos >= fill) ? 0 : int'(pos);
            for (int i = fill; i > at; i--) words[i] = words[i-1];
            words[at] = val;
            fill++;
          end
        end
        OP_ERASE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            at = (pos >= fill) ? 0 : int'(pos);
            for (int i = at; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        OP_GET: begin
          if (fill == 0) r.status = ST_EMPTY;
          else if (pos >= fill) r.status = ST_RANGE;
          else r.read_value = words[pos];
        end
        OP_FIND: begin
          r.found_position = NOT_FOUND;
          for (int i = 0; i < fill; i++) begin
            if (words[i] == val) begin
              r.found_position = FPOS_W'(i);
              break;
            end
          end
        end
        OP_POP, OP_FRONT: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.read_value = words[fill-1];
            if (op == OP_POP) fill--;
          end
        end
        default: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.read_value = words[0];
        end
      endcase
      r.entry_count = CNT_W'(fill);
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [VAL_W-1:0] rd, logic [FPOS_W-1:0] fpos,
                               logic [CNT_W-1:0] cnt, logic [ST_W-1:0] st);
      list_reply_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, actual %h %h %h %h",
                 $time, rd, fpos, cnt, st);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      compare_field("read_value", want.read_value, rd);
      compare_field("found_position", VAL_W'(want.found_position), VAL_W'(fpos));
      compare_field("entry_count", VAL_W'(want.entry_count), VAL_W'(cnt));
      compare_field("status", VAL_W'(want.status), VAL_W'(st));
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [OP_W-1:0]          op_i;
  logic [POS_W-1:0]         position_i;
  logic signed [VAL_W-1:0]  item_value_i;
  logic                     done_o;
  logic signed [VAL_W-1:0]  read_value_o;
  logic signed [FPOS_W-1:0] found_position_o;
  logic [CNT_W-1:0]         entry_count_o;
  logic [ST_W-1:0]          status_o;

  list_scoreboard sb = new();
  int unsigned    quiet_cycles;
  stim_mode_e     mode;
  int             calm_left;

  indexed_list_queue_engine #(
    .DEPTH(LIST_DEPTH),
    .WIDTH(VAL_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .position_i      (position_i),
    .item_value_i    (item_value_i),
    .done_o          (done_o),
    .read_value_o    (read_value_o),
    .found_position_o(found_position_o),
    .entry_count_o   (entry_count_o),
    .status_o        (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results are checked before a command taken at the same edge is noted, so the order is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result(read_value_o, found_position_o, entry_count_o, status_o);
      end
      if (start_i && !busy_o) begin
        sb.note_command(op_e'(op_i), position_i, item_value_i);
      end
      if (done_o || (start_i && !busy_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(op_e op, int pos, logic [VAL_W-1:0] val);
    @(negedge clk_i);
    start_i <= 1'b1;
    op_i <= op;
    position_i <= POS_W'(pos);
    item_value_i <= val;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic random_word();
    op_e              op;
    int               pos;
    logic [VAL_W-1:0] val;
    int               r;
    r = $urandom_range(0, 99);
    case (mode)
      FILLING:  op = (r < 40) ? OP_PUSH : (r < 75) ? OP_INSERT : op_e'($urandom_range(0, 7));
      DRAINING: op = (r < 35) ? OP_POP : (r < 70) ? OP_ERASE : op_e'($urandom_range(0, 7));
      default:  op = op_e'($urandom_range(0, 7));
    endcase
    if (sb.fill > 0 && $urandom_range(0, 3) != 0) pos = $urandom_range(0, sb.fill - 1);
    else pos = $urandom_range(0, 15);
    case ($urandom_range(0, 7))
      0, 1, 2: val = $urandom_range(0, 7);
      3: begin
        case ($urandom_range(0, 3))
          0: val = '0;
          1: val = '1;
          2: val = 32'h8000_0000;
          default: val = 32'h7fff_ffff;
        endcase
      end
      default: val = $urandom();
    endcase
    // Searches mostly look for a word that is in the list.
    if (op == OP_FIND && sb.fill > 0 && $urandom_range(0, 9) < 6) begin
      val = sb.words[$urandom_range(0, sb.fill - 1)];
    end
    send_word(op, pos, val);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = '0;
    position_i = '0;
    item_value_i = '0;
    quiet_cycles = 0;
    mode = FILLING;
    calm_left = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty-list errors, out-of-range positions and the value extremes.
    send_word(OP_BACK, 0, '0);
    send_word(OP_FRONT, 0, '0);
    send_word(OP_POP, 0, '0);
    send_word(OP_ERASE, 3, '0);
    send_word(OP_GET, 0, '0);
    send_word(OP_FIND, 0, 32'h1234_5678);
    send_word(OP_INSERT, 15, 32'h8000_0000);
    idle_for(2);
    send_word(OP_PUSH, 9, 32'h7fff_ffff);
    send_word(OP_PUSH, 0, '0);
    send_word(OP_PUSH, 0, '1);
    send_word(OP_INSERT, 4, 32'h5555_5555);
    send_word(OP_INSERT, 2, 32'haaaa_aaaa);
    idle_for(17);
    send_word(OP_GET, 1, '0);
    send_word(OP_GET, 15, '0);
    send_word(OP_FIND, 0, 32'haaaa_aaaa);
    send_word(OP_FIND, 0, 32'h0001_2345);
    send_word(OP_FRONT, 0, '0);
    send_word(OP_BACK, 0, '0);
    idle_for(9);
    send_word(OP_ERASE, 14, '0);
    send_word(OP_ERASE, 1, '0);
    send_word(OP_POP, 0, '0);
    send_word(OP_GET, 0, '0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      idle_for(gap_length());
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 59) == 0) calm_left = $urandom_range(20, 50);
      random_word();
      // Fill until full, stay a little while to see full errors, then drain to empty.
      if (sb.fill >= LIST_DEPTH && $urandom_range(0, 2) == 0) mode = DRAINING;
      else if (sb.fill == 0 && $urandom_range(0, 2) == 0) mode = FILLING;
      else if ($urandom_range(0, 49) == 0) mode = stim_mode_e'($urandom_range(0, 2));
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk_i);
    repeat (LIST_DEPTH + 4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
